>>> rtl/budgeted_mip_upload_chunker_macros.svh
// Assertion macros used by the chunker RTL.
`ifndef BUDGETED_MIP_UPLOAD_CHUNKER_MACROS_SVH
`define BUDGETED_MIP_UPLOAD_CHUNKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BMUC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BMUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bmuc_pkg.sv
// Package for the mip upload chunker: stream widths and status codes.
`timescale 1ns / 1ps

package bmuc_pkg;

    // Stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 3;
    localparam int OUT_PAD_W   = 2;

    // Fixed result field widths
    localparam int MIP_W   = 4;
    localparam int LB_W    = 12;
    localparam int LE_W    = 13;
    localparam int RW_W    = 13;
    localparam int BYTES_W = 28;
    localparam int TOTAL_W = 32;
    localparam int BPP_W   = 7;
    localparam int BASE_W  = 13;

    // Per-frame budget after reset
    localparam logic [31:0] RESET_BUDGET = 32'd65536;

    // Restoring divider: one quotient bit per cycle over a 32-bit dividend
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Minimum width clamp used for the line weight
    localparam int MIN_LW_WIDTH = 4;

    // Input kinds
    typedef enum logic {
        KIND_FRAME  = 1'b0,
        KIND_UPLOAD = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_MORE    = 2'd0,
        STATUS_DONE    = 2'd1,
        STATUS_BUDGET  = 2'd2,
        STATUS_CLEARED = 2'd3
    } t_status;

endpackage

>>> rtl/budgeted_mip_upload_chunker.sv
// Top level of the budgeted mip upload chunker: sequencer, shared multiplier and divider.
// A frame-start item or an empty pass gives its result from the start state after acceptance.
// Each level that fits steps through dims, two multiplies through the shared multiplier, sum.
// The level that passes the budget adds a third multiply and the bit-serial divider.
// Throughput: one item at a time; ready again once its final result is in the output register.
// Reset: synchronous active low; budget 65536, frame total and resume point zero.
`timescale 1ns / 1ps

`include "budgeted_mip_upload_chunker_macros.svh"

module budgeted_mip_upload_chunker #(
    parameter int MAX_MIPS = 13,
    parameter int MAX_DIM  = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: frame byte budget
    input  logic                               i_cfg_wen,
    input  logic [31:0]                        i_cfg_wdata,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // restart[0], base_width[13:1], base_height[26:14], mip_count[30:27],
    // bits_per_pixel[37:31], block_compressed[38], already_resident[39]
    input  logic [bmuc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // kind[0]
    input  logic [bmuc_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // mip_level[3:0], line_begin[15:4], line_end[28:16], rect_width[41:29],
    // bytes_charged[69:42], frame_total[101:70], zero pad[103:102]
    output logic [bmuc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // rect_valid[0], status[2:1]
    output logic [bmuc_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import bmuc_pkg::*;

    // Derived widths
    localparam int DW  = $clog2(MAX_DIM + 1);        // level width/height
    localparam int AW  = 2 * DW;                     // multiplier operand A
    localparam int BW  = (DW > BPP_W) ? DW : BPP_W;  // multiplier operand B
    localparam int PW  = AW + BW;                    // product
    localparam int WW  = 2 * DW + BPP_W;             // bits before the divide by 8
    localparam int WTW = WW - 3;                     // level weight in bytes
    localparam int SW  = ((WTW > 32) ? WTW : 32) + 1;
    localparam int LW  = DW + 4;                     // line weight in bytes

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LEVEL,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_MUL3,
        ST_DIV,
        ST_FIN
    } t_state;

    // Base size clamp: zero counts as one, oversize counts as MAX_DIM
    function automatic logic [DW-1:0] clamp_base(input logic [BASE_W-1:0] b);
        if (b == '0) begin
            return DW'(1);
        end else if (32'(b) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(b);
        end
    endfunction

    // Registers
    t_state                 r_state, n_state;
    logic [31:0]            r_budget, n_budget;
    logic [31:0]            r_frame_bytes, n_frame_bytes;
    logic [MIP_W-1:0]       r_resume_mip, n_resume_mip;
    logic [LB_W-1:0]        r_resume_line, n_resume_line;
    t_kind                  r_kind, n_kind;
    logic [DW-1:0]          r_base_w, n_base_w;
    logic [DW-1:0]          r_base_h, n_base_h;
    logic [MIP_W-1:0]       r_count, n_count;
    logic [BPP_W-1:0]       r_bpp, n_bpp;
    logic                   r_bc, n_bc;
    logic                   r_res, n_res;
    logic [MIP_W-1:0]       r_m, n_m;
    logic [DW-1:0]          r_w, n_w;
    logic [DW-1:0]          r_h, n_h;
    logic [DW-1:0]          r_line, n_line;
    logic [PW-1:0]          r_prod, n_prod;
    logic [WTW-1:0]         r_weight, n_weight;
    logic [31:0]            r_left, n_left;
    logic [LW-1:0]          r_lw, n_lw;
    logic [LW-1:0]          r_rem, n_rem;
    logic [31:0]            r_dq, n_dq;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user, n_out_user;
    logic                   r_out_last, n_out_last;

    // Input fields
    logic                   in_restart;
    logic [BASE_W-1:0]      in_base_w;
    logic [BASE_W-1:0]      in_base_h;
    logic [MIP_W-1:0]       in_mip_count;
    logic [BPP_W-1:0]       in_bpp;
    logic                   in_bc;
    logic                   in_res;
    t_kind                  in_kind;

    // Shared multiplier
    logic [AW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [PW-1:0]          mul_p;

    // Datapath helpers
    logic                   can_emit;
    logic [DW-1:0]          lvl_w, lvl_h;
    logic [WTW-1:0]         weight;
    logic [SW-1:0]          sum;
    logic                   over;
    logic [31:0]            sat_total;
    logic [DW-1:0]          w4;
    logic [LW-1:0]          mul_lw;
    logic [LW:0]            trial;
    logic                   div_ge;
    logic [29:0]            nbq;
    logic [31:0]            nb;
    logic [32:0]            line_sum;
    logic [DW-1:0]          fin_lend;
    logic                   lvl_last;

    // Result being emitted
    logic                   emit;
    logic                   e_rect;
    logic [MIP_W-1:0]       e_mip;
    logic [LB_W-1:0]        e_lb;
    logic [LE_W-1:0]        e_le;
    logic [RW_W-1:0]        e_w;
    logic [BYTES_W-1:0]     e_bytes;
    logic [TOTAL_W-1:0]     e_total;
    t_status                e_status;
    logic                   e_last;

    // Unpack the input transfer
    assign in_restart   = i_s_axis_tdata[0];
    assign in_base_w    = i_s_axis_tdata[13:1];
    assign in_base_h    = i_s_axis_tdata[26:14];
    assign in_mip_count = i_s_axis_tdata[30:27];
    assign in_bpp       = i_s_axis_tdata[37:31];
    assign in_bc        = i_s_axis_tdata[38];
    assign in_res       = i_s_axis_tdata[39];
    assign in_kind      = t_kind'(i_s_axis_tuser[0]);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    // Output register free this cycle
    assign can_emit = !r_out_valid || i_m_axis_tready;

    // Level dimensions: halve per level, minimum one
    always_comb begin
        lvl_w = r_base_w >> r_m;
        lvl_h = r_base_h >> r_m;
        if (lvl_w == '0) begin
            lvl_w = DW'(1);
        end
        if (lvl_h == '0) begin
            lvl_h = DW'(1);
        end
    end

    // Shared multiplier operand select
    assign w4 = (r_w > DW'(MIN_LW_WIDTH)) ? r_w : DW'(MIN_LW_WIDTH);
    always_comb begin
        unique case (r_state)
            ST_MUL1: begin
                mul_a = AW'(r_h - r_line);
                mul_b = BW'(r_w);
            end
            ST_MUL2: begin
                mul_a = r_prod[AW-1:0];
                mul_b = BW'(r_bpp);
            end
            ST_MUL3: begin
                mul_a = AW'(w4);
                mul_b = BW'(r_bpp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p  = PW'(mul_a) * PW'(mul_b);
    assign mul_lw = mul_p[LW+2:3];

    // Budget charge for the current level
    assign weight    = r_prod[WW-1:3];
    assign sum       = SW'(r_frame_bytes) + SW'(weight);
    assign over      = sum > SW'(r_budget);
    assign sat_total = (sum > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum[31:0];
    assign lvl_last  = (r_m + MIP_W'(1)) >= r_count;

    // Divider step: shift in one dividend bit, subtract when it fits
    assign trial  = {r_rem, r_dq[31]};
    assign div_ge = trial >= {1'b0, r_lw};

    // Block end: multiple of four lines, at least four, clipped to the height
    assign nbq      = r_dq[31:2];
    assign nb       = {((nbq == '0) ? 30'd1 : nbq), 2'b00};
    assign line_sum = 33'(r_line) + 33'(nb);
    always_comb begin
        if (r_lw == '0) begin
            fin_lend = r_h;
        end else if (line_sum < 33'(r_h)) begin
            fin_lend = DW'(line_sum);
        end else begin
            fin_lend = r_h;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_budget      = r_budget;
        n_frame_bytes = r_frame_bytes;
        n_resume_mip  = r_resume_mip;
        n_resume_line = r_resume_line;
        n_kind        = r_kind;
        n_base_w      = r_base_w;
        n_base_h      = r_base_h;
        n_count       = r_count;
        n_bpp         = r_bpp;
        n_bc          = r_bc;
        n_res         = r_res;
        n_m           = r_m;
        n_w           = r_w;
        n_h           = r_h;
        n_line        = r_line;
        n_prod        = r_prod;
        n_weight      = r_weight;
        n_left        = r_left;
        n_lw          = r_lw;
        n_rem         = r_rem;
        n_dq          = r_dq;
        n_cnt         = r_cnt;
        emit          = 1'b0;
        e_rect        = 1'b0;
        e_mip         = '0;
        e_lb          = '0;
        e_le          = '0;
        e_w           = '0;
        e_bytes       = '0;
        e_total       = '0;
        e_status      = STATUS_MORE;
        e_last        = 1'b0;

        if (i_cfg_wen) begin
            n_budget = i_cfg_wdata;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind   = in_kind;
                    n_base_w = clamp_base(in_base_w);
                    n_base_h = clamp_base(in_base_h);
                    n_count  = (32'(in_mip_count) > MAX_MIPS) ? MIP_W'(MAX_MIPS)
                                                               : in_mip_count;
                    n_bpp    = in_bpp;
                    n_bc     = in_bc;
                    n_res    = in_res;
                    if (in_kind == KIND_UPLOAD && in_restart) begin
                        n_resume_mip  = '0;
                        n_resume_line = '0;
                    end
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_kind == KIND_FRAME) begin
                    // frame start clears the running total
                    if (can_emit) begin
                        emit          = 1'b1;
                        e_status      = STATUS_CLEARED;
                        e_last        = 1'b1;
                        n_frame_bytes = '0;
                        n_state       = ST_IDLE;
                    end
                end else if (r_resume_mip == '0 && r_resume_line == '0 &&
                             (!(r_count > MIP_W'(1) && r_bc) || r_res)) begin
                    // texture with nothing to upload
                    if (can_emit) begin
                        emit     = 1'b1;
                        e_total  = r_frame_bytes;
                        e_status = STATUS_DONE;
                        e_last   = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_m     = r_resume_mip;
                    n_state = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                if (r_m >= r_count) begin
                    // chain already finished
                    if (can_emit) begin
                        emit     = 1'b1;
                        e_total  = r_frame_bytes;
                        e_status = STATUS_DONE;
                        e_last   = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_w     = lvl_w;
                    n_h     = lvl_h;
                    n_line  = (32'(r_resume_line) < 32'(lvl_h)) ? DW'(r_resume_line) : '0;
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_prod  = mul_p;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_prod  = mul_p;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (!over) begin
                    // whole rest of the level fits
                    if (can_emit) begin
                        emit          = 1'b1;
                        e_rect        = 1'b1;
                        e_mip         = r_m;
                        e_lb          = LB_W'(r_line);
                        e_le          = LE_W'(r_h);
                        e_w           = RW_W'(r_w);
                        e_bytes       = BYTES_W'(weight);
                        e_total       = sat_total;
                        e_status      = lvl_last ? STATUS_DONE : STATUS_MORE;
                        e_last        = lvl_last;
                        n_frame_bytes = sat_total;
                        n_resume_line = '0;
                        n_resume_mip  = r_m + MIP_W'(1);
                        n_m           = r_m + MIP_W'(1);
                        n_state       = lvl_last ? ST_IDLE : ST_LEVEL;
                    end
                end else begin
                    // budget passes here: size a block from what was left
                    n_left        = (r_budget > r_frame_bytes) ? (r_budget - r_frame_bytes)
                                                               : 32'd0;
                    n_frame_bytes = sat_total;
                    n_weight      = weight;
                    n_state       = ST_MUL3;
                end
            end
            ST_MUL3: begin
                n_lw    = mul_lw;
                n_rem   = '0;
                n_dq    = r_left;
                n_cnt   = '0;
                n_state = (mul_lw == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                n_rem = div_ge ? LW'(trial - {1'b0, r_lw}) : LW'(trial);
                n_dq  = {r_dq[30:0], div_ge};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_rect   = 1'b1;
                    e_mip    = r_m;
                    e_lb     = LB_W'(r_line);
                    e_le     = LE_W'(fin_lend);
                    e_w      = RW_W'(r_w);
                    e_bytes  = BYTES_W'(r_weight);
                    e_total  = r_frame_bytes;
                    e_status = STATUS_BUDGET;
                    e_last   = 1'b1;
                    if (fin_lend == r_h) begin
                        n_resume_line = '0;
                        n_resume_mip  = r_m + MIP_W'(1);
                    end else begin
                        n_resume_line = LB_W'(fin_lend);
                        n_resume_mip  = r_m;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output register: load on emit, drop once taken
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        n_out_data = emit ? {{OUT_PAD_W{1'b0}}, e_total, e_bytes, e_w, e_le, e_lb, e_mip}
                          : r_out_data;
        n_out_user = emit ? {e_status, e_rect} : r_out_user;
        n_out_last = emit ? e_last : r_out_last;
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_budget      <= RESET_BUDGET;
            r_frame_bytes <= '0;
            r_resume_mip  <= '0;
            r_resume_line <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_budget      <= n_budget;
            r_frame_bytes <= n_frame_bytes;
            r_resume_mip  <= n_resume_mip;
            r_resume_line <= n_resume_line;
            r_out_valid   <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_base_w   <= n_base_w;
        r_base_h   <= n_base_h;
        r_count    <= n_count;
        r_bpp      <= n_bpp;
        r_bc       <= n_bc;
        r_res      <= n_res;
        r_m        <= n_m;
        r_w        <= n_w;
        r_h        <= n_h;
        r_line     <= n_line;
        r_prod     <= n_prod;
        r_weight   <= n_weight;
        r_left     <= n_left;
        r_lw       <= n_lw;
        r_rem      <= n_rem;
        r_dq       <= n_dq;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    // Checks
    `BMUC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken again right after a transfer")
    `BMUC_ASSERT_NOW(a_budget_ends_pass, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[2:1] == STATUS_BUDGET), o_m_axis_tlast, "budget result not marked last")
    `BMUC_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV, r_lw != '0, "divider running with zero line weight")
    `BMUC_ASSERT_NEXT(a_frame_clear, i_clk, i_rst_n, emit && (e_status == STATUS_CLEARED), r_frame_bytes == '0, "frame total not cleared")

endmodule
